@@ rtl/hbp_pkg.sv @@
// ============================================================================
// hbp_pkg: shared types and constants of the hash based random generator
// Transaction payloads, action codes, hash unit control and round constants.
// ============================================================================
package hbp_pkg;

    // Default depth of the queue between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // Action codes of an input transaction
    localparam logic [1:0] ACT_SEED = 2'd0;
    localparam logic [1:0] ACT_WORD = 2'd1;
    localparam logic [1:0] ACT_BYTE = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    // Hash sizes
    localparam logic [5:0] SHA1_BYTES   = 6'd20;
    localparam logic [5:0] SHA256_BYTES = 6'd32;
    localparam logic [3:0] SHA1_WORDS   = 4'd5;
    localparam logic [3:0] SHA256_WORDS = 4'd8;
    localparam logic [31:0] PAD_WORD    = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] seed_word;
        logic        seed_last;
    } in_t;

    typedef struct packed {
        logic [31:0] random_value;
        logic        byte_only;
    } out_t;

    // Class of a queued transaction
    typedef enum logic [1:0] {
        KIND_SEED = 2'd0,
        KIND_WORD = 2'd1,
        KIND_BYTE = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] word;
        logic        last;
    } item_t;

    // Control of the hash unit
    typedef struct packed {
        logic        init;
        logic        start;
        logic        wr_en;
        logic [3:0]  wr_idx;
        logic [31:0] wr_data;
    } sha_ctrl_t;

    typedef logic [7:0][31:0] digest_t;

    // Initial chaining value for the selected hash
    function automatic digest_t hash_iv(logic mode);
        digest_t v;
        v = '0;
        if (mode)
        begin
            v[0] = 32'h6a09e667; v[1] = 32'hbb67ae85;
            v[2] = 32'h3c6ef372; v[3] = 32'ha54ff53a;
            v[4] = 32'h510e527f; v[5] = 32'h9b05688c;
            v[6] = 32'h1f83d9ab; v[7] = 32'h5be0cd19;
        end
        else
        begin
            v[0] = 32'h67452301; v[1] = 32'hefcdab89;
            v[2] = 32'h98badcfe; v[3] = 32'h10325476;
            v[4] = 32'hc3d2e1f0;
        end
        return v;
    endfunction

    // SHA-256 round constants
    function automatic logic [31:0] k256(logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/hbp_front.sv @@
// ============================================================================
// hbp_front: input front end
// Accepts transactions, drops unused action codes, classifies the rest and
// holds them in a short queue for the back end.
// ============================================================================
module hbp_front #(
    parameter int DEPTH = hbp_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  hbp_pkg::in_t   in_data,
    output logic           item_valid,
    input  logic           item_pop,
    output hbp_pkg::item_t item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hbp_pkg::item_t q_reg [DEPTH];
    hbp_pkg::item_t new_item;
    logic [PW-1:0]  wp_reg, wp_next, rp_reg, rp_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           push, pop;

    assign in_ready   = (cnt_reg != CW'(DEPTH));
    assign item_valid = (cnt_reg != '0);
    assign item       = q_reg[rp_reg];
    assign pop        = item_pop && item_valid;
    assign push       = in_valid && in_ready && (in_data.action != hbp_pkg::ACT_NONE);

    // Classify the incoming transaction
    always_comb
    begin
        new_item.word = in_data.seed_word;
        new_item.last = in_data.seed_last;
        unique case (in_data.action)
            hbp_pkg::ACT_SEED: new_item.kind = hbp_pkg::KIND_SEED;
            hbp_pkg::ACT_WORD: new_item.kind = hbp_pkg::KIND_WORD;
            default:           new_item.kind = hbp_pkg::KIND_BYTE;
        endcase
    end

    // Queue pointers and fill count
    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
        end
        if (pop)
        begin
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= new_item;
        end
    end

endmodule

@@ rtl/hbp_sha.sv @@
// ============================================================================
// hbp_sha: iterative SHA-1 / SHA-256 compression unit
// One round per cycle over a 16 word message window, then a final step adds
// the working variables into the chaining value.
// ============================================================================
module hbp_sha (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                mode,
    input  hbp_pkg::sha_ctrl_t  ctrl,
    output logic                busy,
    output hbp_pkg::digest_t    digest
);

    hbp_pkg::digest_t  h_reg, h_next, wv_reg, wv_next, rv;
    logic [15:0][31:0] msg_reg, msg_next;
    logic [6:0]        rnd_reg, rnd_next, last_rnd;
    logic              run_reg, run_next, fin_reg, fin_next;
    logic [31:0]       w_new, t1, t2, f1, k1;

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] rotl(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    assign busy     = run_reg;
    assign digest   = h_reg;
    assign last_rnd = mode ? 7'd63 : 7'd79;

    // Message schedule: next word entering the window
    always_comb
    begin
        if (mode)
        begin
            w_new = (rotr(msg_reg[14], 17) ^ rotr(msg_reg[14], 19) ^ (msg_reg[14] >> 10))
                  + msg_reg[9]
                  + (rotr(msg_reg[1], 7) ^ rotr(msg_reg[1], 18) ^ (msg_reg[1] >> 3))
                  + msg_reg[0];
        end
        else
        begin
            w_new = rotl(msg_reg[13] ^ msg_reg[8] ^ msg_reg[2] ^ msg_reg[0], 1);
        end
    end

    // One round
    always_comb
    begin
        rv = wv_reg;
        t1 = '0;
        t2 = '0;
        f1 = '0;
        k1 = '0;
        if (mode)
        begin
            t1 = wv_reg[7]
               + (rotr(wv_reg[4], 6) ^ rotr(wv_reg[4], 11) ^ rotr(wv_reg[4], 25))
               + ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]))
               + hbp_pkg::k256(rnd_reg[5:0]) + msg_reg[0];
            t2 = (rotr(wv_reg[0], 2) ^ rotr(wv_reg[0], 13) ^ rotr(wv_reg[0], 22))
               + ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));
            rv[0] = t1 + t2;
            rv[1] = wv_reg[0];
            rv[2] = wv_reg[1];
            rv[3] = wv_reg[2];
            rv[4] = wv_reg[3] + t1;
            rv[5] = wv_reg[4];
            rv[6] = wv_reg[5];
            rv[7] = wv_reg[6];
        end
        else
        begin
            priority if (rnd_reg < 7'd20)
            begin
                f1 = (wv_reg[1] & wv_reg[2]) | (~wv_reg[1] & wv_reg[3]);
                k1 = 32'h5a827999;
            end
            else if (rnd_reg < 7'd40)
            begin
                f1 = wv_reg[1] ^ wv_reg[2] ^ wv_reg[3];
                k1 = 32'h6ed9eba1;
            end
            else if (rnd_reg < 7'd60)
            begin
                f1 = (wv_reg[1] & wv_reg[2]) | (wv_reg[1] & wv_reg[3])
                   | (wv_reg[2] & wv_reg[3]);
                k1 = 32'h8f1bbcdc;
            end
            else
            begin
                f1 = wv_reg[1] ^ wv_reg[2] ^ wv_reg[3];
                k1 = 32'hca62c1d6;
            end
            rv[0] = rotl(wv_reg[0], 5) + f1 + wv_reg[4] + k1 + msg_reg[0];
            rv[1] = wv_reg[0];
            rv[2] = rotl(wv_reg[1], 30);
            rv[3] = wv_reg[2];
            rv[4] = wv_reg[3];
        end
    end

    // Sequencing: load, rounds, final add
    always_comb
    begin
        h_next   = h_reg;
        wv_next  = wv_reg;
        msg_next = msg_reg;
        rnd_next = rnd_reg;
        run_next = run_reg;
        fin_next = fin_reg;
        if (fin_reg)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (mode || (i < int'(hbp_pkg::SHA1_WORDS)))
                begin
                    h_next[i] = h_reg[i] + wv_reg[i];
                end
            end
            run_next = 1'b0;
            fin_next = 1'b0;
        end
        else if (run_reg)
        begin
            wv_next  = rv;
            msg_next = {w_new, msg_reg[15:1]};
            rnd_next = rnd_reg + 7'd1;
            if (rnd_reg == last_rnd)
            begin
                fin_next = 1'b1;
            end
        end
        else
        begin
            if (ctrl.init)
            begin
                h_next = hbp_pkg::hash_iv(mode);
            end
            if (ctrl.wr_en)
            begin
                msg_next[ctrl.wr_idx] = ctrl.wr_data;
            end
            if (ctrl.start)
            begin
                wv_next  = h_reg;
                rnd_next = '0;
                run_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg   <= hbp_pkg::hash_iv(1'b1);
            rnd_reg <= '0;
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
        end
        else
        begin
            h_reg   <= h_next;
            rnd_reg <= rnd_next;
            run_reg <= run_next;
            fin_reg <= fin_next;
        end
    end

    // Working variables and message window
    always_ff @(posedge clk)
    begin
        wv_reg  <= wv_next;
        msg_reg <= msg_next;
    end

endmodule

@@ rtl/hbp_back.sv @@
// ============================================================================
// hbp_back: generator back end
// Runs seeding, padding, buffer refill and state update over the hash unit
// and delivers results through an output register.
// ============================================================================
module hbp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_data,
    output logic               hash_mode,
    input  logic               item_valid,
    input  hbp_pkg::item_t     item,
    output logic               item_pop,
    output hbp_pkg::sha_ctrl_t sha_ctrl,
    input  logic               sha_busy,
    input  hbp_pkg::digest_t   sha_digest,
    output logic               out_valid,
    input  logic               out_ready,
    output hbp_pkg::out_t      out_data
);

    typedef enum logic [13:0] {
        ST_IDLE     = 14'b00000000000001,
        ST_ABS_WAIT = 14'b00000000000010,
        ST_PAD_MARK = 14'b00000000000100,
        ST_PAD_ZERO = 14'b00000000001000,
        ST_PAD_WAIT = 14'b00000000010000,
        ST_LEN_HI   = 14'b00000000100000,
        ST_LEN_LO   = 14'b00000001000000,
        ST_FIN_WAIT = 14'b00000010000000,
        ST_REQ      = 14'b00000100000000,
        ST_REF_INIT = 14'b00001000000000,
        ST_REF_ABS  = 14'b00010000000000,
        ST_UPD      = 14'b00100000000000,
        ST_UPD_FIX  = 14'b01000000000000,
        ST_OUT      = 14'b10000000000000
    } state_t;

    state_t           state_reg, state_next;
    logic             mode_reg, mode_next;
    hbp_pkg::digest_t gs_reg, gs_next, db_reg, db_next;
    logic [5:0]       pos_reg, pos_next;
    logic [63:0]      cnt_reg, cnt_next, cnt_inc;
    logic [4:0]       ptr_reg, ptr_next, pad_end;
    logic             extra_reg, extra_next, refill_reg, refill_next;
    logic             last_reg, last_next, bonly_reg, bonly_next;
    logic             chg_reg, chg_next, out_valid_reg, out_valid_next;
    logic [2:0]       left_reg, left_next;
    logic [31:0]      acc_reg, acc_next, cur_word;
    logic [1:0]       carry_reg, carry_next;
    logic [34:0]      upd;
    logic [3:0]       n_words;
    logic [5:0]       n_bytes;
    logic [4:0]       sh;
    logic [7:0]       cur_byte;
    hbp_pkg::out_t    out_reg, out_next;

    // Bytewise signed add of state and digest with a running carry
    function automatic logic [34:0] upd_word(logic [31:0] g, logic [31:0] d,
                                             logic [1:0] c_in);
        logic [31:0] r;
        logic [1:0]  c;
        logic        ch;
        logic [9:0]  s;
        logic [7:0]  gb, dbt;
        r  = '0;
        c  = c_in;
        ch = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            gb  = g[31 - 8 * k -: 8];
            dbt = d[31 - 8 * k -: 8];
            s   = {{2{gb[7]}}, gb} + {{2{dbt[7]}}, dbt} + {{8{c[1]}}, c};
            r[31 - 8 * k -: 8] = s[7:0];
            ch  = ch | (s[7:0] != gb);
            c   = s[9:8];
        end
        return {r, c, ch};
    endfunction

    assign hash_mode = mode_reg;
    assign n_words   = mode_reg ? hbp_pkg::SHA256_WORDS : hbp_pkg::SHA1_WORDS;
    assign n_bytes   = mode_reg ? hbp_pkg::SHA256_BYTES : hbp_pkg::SHA1_BYTES;
    assign cnt_inc   = cnt_reg + 64'd4;
    assign pad_end   = extra_reg ? 5'd16 : 5'd14;
    assign cur_word  = db_reg[pos_reg[4:2]];
    assign sh        = {~pos_reg[1:0], 3'b000};
    assign cur_byte  = 8'(cur_word >> sh);
    assign upd       = upd_word(gs_reg[ptr_reg[2:0]], db_reg[ptr_reg[2:0]], carry_reg);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        gs_next        = gs_reg;
        db_next        = db_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        extra_next     = extra_reg;
        refill_next    = refill_reg;
        last_next      = last_reg;
        bonly_next     = bonly_reg;
        chg_next       = chg_reg;
        left_next      = left_reg;
        acc_next       = acc_reg;
        carry_next     = carry_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        item_pop       = 1'b0;
        sha_ctrl       = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    unique case (item.kind)
                        hbp_pkg::KIND_SEED:
                        begin
                            // Absorb one seed word, low byte first
                            sha_ctrl.init    = (cnt_reg == '0);
                            sha_ctrl.wr_en   = 1'b1;
                            sha_ctrl.wr_idx  = cnt_reg[5:2];
                            sha_ctrl.wr_data = {item.word[7:0], item.word[15:8],
                                                item.word[23:16], item.word[31:24]};
                            cnt_next    = cnt_inc;
                            last_next   = item.last;
                            refill_next = 1'b0;
                            if (cnt_inc[5:0] == 6'd0)
                            begin
                                sha_ctrl.start = 1'b1;
                                state_next     = ST_ABS_WAIT;
                            end
                            else if (item.last)
                            begin
                                state_next = ST_PAD_MARK;
                            end
                        end
                        hbp_pkg::KIND_WORD:
                        begin
                            cnt_next   = '0;
                            left_next  = 3'd4;
                            acc_next   = '0;
                            bonly_next = 1'b0;
                            state_next = ST_REQ;
                        end
                        default:
                        begin
                            cnt_next   = '0;
                            left_next  = 3'd1;
                            acc_next   = '0;
                            bonly_next = 1'b1;
                            state_next = ST_REQ;
                        end
                    endcase
                end
            end
            ST_ABS_WAIT:
            begin
                if (!sha_busy)
                begin
                    state_next = last_reg ? ST_PAD_MARK : ST_IDLE;
                end
            end
            ST_PAD_MARK:
            begin
                // Marker word right after the message
                sha_ctrl.wr_en   = 1'b1;
                sha_ctrl.wr_idx  = cnt_reg[5:2];
                sha_ctrl.wr_data = hbp_pkg::PAD_WORD;
                ptr_next   = {1'b0, cnt_reg[5:2]} + 5'd1;
                extra_next = (cnt_reg[5:2] >= 4'd14);
                state_next = ST_PAD_ZERO;
            end
            ST_PAD_ZERO:
            begin
                if (ptr_reg != pad_end)
                begin
                    sha_ctrl.wr_en   = 1'b1;
                    sha_ctrl.wr_idx  = ptr_reg[3:0];
                    sha_ctrl.wr_data = '0;
                    ptr_next = ptr_reg + 5'd1;
                end
                else if (extra_reg)
                begin
                    // No room for the length: extra block
                    sha_ctrl.start = 1'b1;
                    extra_next     = 1'b0;
                    ptr_next       = '0;
                    state_next     = ST_PAD_WAIT;
                end
                else
                begin
                    state_next = ST_LEN_HI;
                end
            end
            ST_PAD_WAIT:
            begin
                if (!sha_busy)
                begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_LEN_HI:
            begin
                sha_ctrl.wr_en   = 1'b1;
                sha_ctrl.wr_idx  = 4'd14;
                sha_ctrl.wr_data = cnt_reg[60:29];
                state_next = ST_LEN_LO;
            end
            ST_LEN_LO:
            begin
                sha_ctrl.wr_en   = 1'b1;
                sha_ctrl.wr_idx  = 4'd15;
                sha_ctrl.wr_data = {cnt_reg[28:0], 3'b000};
                sha_ctrl.start   = 1'b1;
                state_next = ST_FIN_WAIT;
            end
            ST_FIN_WAIT:
            begin
                if (!sha_busy)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        if (mode_reg || (i < int'(hbp_pkg::SHA1_WORDS)))
                        begin
                            db_next[i] = sha_digest[i];
                            if (!refill_reg)
                            begin
                                gs_next[i] = sha_digest[i];
                            end
                        end
                    end
                    cnt_next = '0;
                    if (refill_reg)
                    begin
                        ptr_next   = '0;
                        carry_next = 2'b01;
                        chg_next   = 1'b0;
                        state_next = ST_UPD;
                    end
                    else
                    begin
                        pos_next   = n_bytes;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REQ:
            begin
                if (pos_reg >= n_bytes)
                begin
                    refill_next = 1'b1;
                    state_next  = ST_REF_INIT;
                end
                else
                begin
                    acc_next  = {acc_reg[23:0], cur_byte};
                    pos_next  = pos_reg + 6'd1;
                    left_next = left_reg - 3'd1;
                    if (left_reg == 3'd1)
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_REF_INIT:
            begin
                sha_ctrl.init = 1'b1;
                cnt_next      = '0;
                ptr_next      = '0;
                state_next    = ST_REF_ABS;
            end
            ST_REF_ABS:
            begin
                // Hash the generator state, one word a cycle
                sha_ctrl.wr_en   = 1'b1;
                sha_ctrl.wr_idx  = ptr_reg[3:0];
                sha_ctrl.wr_data = gs_reg[ptr_reg[2:0]];
                cnt_next = cnt_inc;
                ptr_next = ptr_reg + 5'd1;
                if (ptr_reg[3:0] == n_words - 4'd1)
                begin
                    state_next = ST_PAD_MARK;
                end
            end
            ST_UPD:
            begin
                gs_next[ptr_reg[2:0]] = upd[34:3];
                carry_next = upd[2:1];
                chg_next   = chg_reg | upd[0];
                ptr_next   = ptr_reg + 5'd1;
                if (ptr_reg[3:0] == n_words - 4'd1)
                begin
                    state_next = ST_UPD_FIX;
                end
            end
            ST_UPD_FIX:
            begin
                if (!chg_reg)
                begin
                    gs_next[0][31:24] = gs_reg[0][31:24] + 8'd1;
                end
                pos_next   = '0;
                state_next = ST_REQ;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next        = 1'b1;
                    out_next.random_value = acc_reg;
                    out_next.byte_only    = bonly_reg;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Mode change drops a partial seed and empties the buffer
        if (cfg_we && (cfg_data != mode_reg))
        begin
            mode_next = cfg_data;
            cnt_next  = '0;
            pos_next  = cfg_data ? hbp_pkg::SHA256_BYTES : hbp_pkg::SHA1_BYTES;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b1;
            gs_reg        <= '0;
            db_reg        <= '0;
            pos_reg       <= hbp_pkg::SHA256_BYTES;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            extra_reg     <= 1'b0;
            refill_reg    <= 1'b0;
            last_reg      <= 1'b0;
            chg_reg       <= 1'b0;
            left_reg      <= '0;
            carry_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            gs_reg        <= gs_next;
            db_reg        <= db_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            extra_reg     <= extra_next;
            refill_reg    <= refill_next;
            last_reg      <= last_next;
            chg_reg       <= chg_next;
            left_reg      <= left_next;
            carry_reg     <= carry_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload and byte accumulator
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        bonly_reg <= bonly_next;
        out_reg   <= out_next;
    end

endmodule

@@ rtl/hash_based_prng.sv @@
// A seed word that closes a 64 byte block starts a compression; a closing seed
// word adds the padding and a final compression. A request is served from the
// buffer; when the buffer runs empty, a refill hashes the generator state in
// the hash unit and then updates the state. Throughput: one transaction per
// cycle into the queue while it is not full, work one at a time.
// Reset: asynchronous; state and buffer zero, buffer empty, SHA-256 selected.
// ============================================================================
// hash_based_prng: hash based pseudo random generator
// Front queue, sequencing back end and iterative SHA-1 / SHA-256 unit.
// ============================================================================
module hash_based_prng #(
    parameter int QUEUE_DEPTH = hbp_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  hbp_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output hbp_pkg::out_t out_data,
    input  logic          cfg_we,
    input  logic          cfg_data
);

    logic               item_valid, item_pop, sha_busy, hash_mode;
    hbp_pkg::item_t     item;
    hbp_pkg::sha_ctrl_t sha_ctrl;
    hbp_pkg::digest_t   sha_digest;

    // Transaction front end and queue
    hbp_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item)
    );

    // Sequencer and result register
    hbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .hash_mode  (hash_mode),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .sha_ctrl   (sha_ctrl),
        .sha_busy   (sha_busy),
        .sha_digest (sha_digest),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // Compression unit; mode follows the back end register
    hbp_sha u_sha (
        .clk    (clk),
        .rst_n  (rst_n),
        .mode   (hash_mode),
        .ctrl   (sha_ctrl),
        .busy   (sha_busy),
        .digest (sha_digest)
    );

endmodule
